// ----- rtl/core/directory_inode_allocator_macros.svh -----
// Assertion macros for the directory inode allocator.
// Depends on nothing; included by modules that assert.
`ifndef DIRECTORY_INODE_ALLOCATOR_MACROS_SVH
`define DIRECTORY_INODE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define DIA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DIA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DIA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/dia_pkg.sv -----
// Shared types and constants of the directory inode allocator.
// No dependencies.
package dia_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CntW = 16;
  localparam int unsigned TotW = 19;
  localparam int unsigned InoW = 12;

  typedef enum logic [1:0] {
    REQ_ALLOC_DIR = 2'd0, REQ_ALLOC_FILE = 2'd1, REQ_LOAD = 2'd2, REQ_BIT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOSPC = 2'd1, ST_INSANE = 2'd2, ST_LOADED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_GROUPS = 2'd0, CFG_IPG = 2'd1, CFG_FIRST = 2'd2, CFG_TOTAL = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]    req_type;
    logic [2:0]    group_index;
    logic [15:0]   free_inodes_value;
    logic [15:0]   free_blocks_value;
    logic [15:0]   used_dirs_value;
    logic [7:0]    bit_index;
    logic          bit_value;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [11:0]   inode_number;
    logic [2:0]    chosen_group;
    logic [18:0]   free_inodes_total;
    logic [18:0]   directories_total;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;     // take request
    logic sum_step;    // accumulate one group
    logic div_step;    // one divider step
    logic pick_step;   // examine one group
    logic scan_step;   // examine one bitmap bit
    logic commit;      // apply allocation
    logic finish;      // latch result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic pick_last;
    logic scan_found;
    logic scan_fail;
    logic is_alloc;
    logic no_group;
  } sts_t;
endpackage

// ----- rtl/core/dia_if.sv -----
// Valid/ready channel interface for the directory inode allocator.
// Depends on nothing; payload type is a parameter.
interface dia_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dia_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module dia_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/core/dia_ctrl.sv -----
// Sequencer of the directory inode allocator.
// Depends on dia_pkg and the assertion macros.
`include "directory_inode_allocator_macros.svh"
module dia_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  logic          clr_busy_i,
  output dia_pkg::cmd_t cmd_o,
  input  dia_pkg::sts_t sts_i
);
  import dia_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_SUM = 8'b00000010, S_DIV = 8'b00000100,
    S_PICK = 8'b00001000, S_SCAN = 8'b00010000, S_WAIT = 8'b00100000,
    S_DONE = 8'b01000000, S_OUT = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // in_ready held low during the post-reset clear sweep
  assign in_ready_o  = (state_q == S_IDLE) && !clr_busy_i;
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.capture = 1'b1;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) state_d = sts_i.is_alloc ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_last) state_d = S_WAIT;
      end
      S_WAIT: begin
        // RAM read latency before the first bit is seen
        if (sts_i.no_group) state_d = S_DONE;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_found) begin
          cmd_o.commit = 1'b1;
          state_d = S_SUM;
        end else if (sts_i.scan_fail) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  `DIA_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `DIA_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `DIA_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o), "accept while result pending")
endmodule

// ----- rtl/core/dia_dp.sv -----
// Datapath: group counters, bitmap RAM, divider, picker and bit scanner.
// Depends on dia_pkg and dia_ram.
module dia_dp #(
  parameter int unsigned MaxGroups = 8,
  parameter int unsigned MaxIpg    = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dia_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dia_pkg::CfgDataW-1:0] cfg_data_i,
  input  dia_pkg::req_t            req_i,
  input  dia_pkg::cmd_t            cmd_i,
  output dia_pkg::sts_t            sts_o,
  output logic                     clr_busy_o,
  output dia_pkg::rsp_t            rsp_o
);
  import dia_pkg::*;

  localparam int unsigned GW = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int unsigned BW = $clog2(MaxIpg);
  localparam int unsigned AW = GW + BW;
  localparam int unsigned Depth = MaxGroups * MaxIpg;
  localparam int unsigned GCW = $clog2(MaxGroups + 1);
  localparam int unsigned ICW = $clog2(MaxIpg + 1);
  localparam int unsigned SW = CntW + GW + 1;

  // configuration registers
  logic [3:0]  groups_q;
  logic [8:0]  ipg_q;
  logic [11:0] first_q, total_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= 4'd8; ipg_q <= 9'd256; first_q <= 12'd11; total_q <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_GROUPS: groups_q <= cfg_data_i[3:0];
        CFG_IPG:    ipg_q <= cfg_data_i[8:0];
        CFG_FIRST:  first_q <= cfg_data_i;
        CFG_TOTAL:  total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped group count and inodes per group
  logic [GCW-1:0] eff_g;
  logic [ICW-1:0] eff_ipg;
  always_comb begin
    if (groups_q == 4'd0) eff_g = GCW'(1);
    else if (32'(groups_q) > MaxGroups) eff_g = GCW'(MaxGroups);
    else eff_g = GCW'(groups_q);
    if (ipg_q == 9'd0) eff_ipg = ICW'(1);
    else if (32'(ipg_q) > MaxIpg) eff_ipg = ICW'(MaxIpg);
    else eff_ipg = ICW'(ipg_q);
  end

  // per-group counters (reset to zero)
  logic [CntW-1:0] fi_q [MaxGroups];
  logic [CntW-1:0] fb_q [MaxGroups];
  logic [CntW-1:0] ud_q [MaxGroups];

  req_t req_q;
  logic [GW-1:0] gi;     // loop group index
  logic [GW-1:0] grp_q;  // scan group
  logic [BW:0]   bit_q;
  logic [GCW-1:0] tries_q, idx_q;
  logic [SW-1:0] sfi_q, sud_q, avg_q, rem_q;
  logic [4:0]    dcnt_q;
  logic          best_v_q;
  logic [GW-1:0] best_q;
  logic [1:0]    stat_q;
  logic [11:0]   ino_q;
  logic [GW-1:0] cg_q;
  logic          clr_q;
  logic [AW:0]   clr_cnt_q;
  logic          alloc_done_q;  // allocation applied, only totals remain

  assign gi = idx_q[GW-1:0];
  assign sts_o.is_alloc = (req_e'(req_q.req_type) == REQ_ALLOC_DIR) && !alloc_done_q;
  assign sts_o.sum_last = (idx_q + GCW'(1) >= eff_g);
  assign sts_o.div_last = (dcnt_q == 5'(SW - 1));
  assign sts_o.pick_last = sts_o.sum_last;
  assign sts_o.no_group = !best_v_q;

  // bitmap RAM: scan read, clear sweep, load write, allocation write
  logic          ram_we, ram_wd, ram_rd;
  logic [AW-1:0] ram_a;
  logic          lgrp_ok, lbit_ok;
  assign lgrp_ok = (32'(req_i.group_index) < MaxGroups);
  assign lbit_ok = (32'(req_i.bit_index) < MaxIpg);
  always_comb begin
    ram_we = 1'b0; ram_wd = 1'b0;
    ram_a  = {grp_q, bit_q[BW-1:0]};
    if (clr_q) begin
      ram_we = 1'b1; ram_a = clr_cnt_q[AW-1:0];
    end else if (cmd_i.capture && req_e'(req_i.req_type) == REQ_BIT && lgrp_ok && lbit_ok) begin
      ram_we = 1'b1; ram_wd = req_i.bit_value;
      ram_a = {GW'(req_i.group_index), BW'(req_i.bit_index)};
    end else if (cmd_i.commit) begin
      ram_we = 1'b1; ram_wd = 1'b1;
      ram_a = {grp_q, bit_q[BW-1:0] - BW'(1)};
    end
  end

  dia_ram #(.Width(1), .Depth(Depth)) u_bitmap (
    .clk_i, .we_i(ram_we), .addr_i(ram_a), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // scan: RAM returns bit (bit_q - 1) each step; bit_q of zero is a bubble
  // while the first read of a group is in flight
  logic [BW:0] rd_bit;
  logic        grp_end;
  logic        rd_ok;
  assign rd_bit = bit_q - (BW+1)'(1);
  assign rd_ok = (bit_q != '0);
  assign grp_end = (rd_bit + (BW+1)'(1) >= (BW+1)'(eff_ipg));
  assign sts_o.scan_found = rd_ok && !ram_rd;
  assign sts_o.scan_fail = rd_ok && ram_rd && grp_end && (tries_q + GCW'(1) >= eff_g);

  // absolute number for the hit: bit + grp*ipg + 1
  logic [AW+1:0] ino_w;
  assign ino_w = (AW+2)'(rd_bit) + (AW+2)'(grp_q) * (AW+2)'(eff_ipg) + (AW+2)'(1);
  logic insane;
  assign insane = (ino_w < (AW+2)'(first_q)) || (ino_w > (AW+2)'(total_q));

  logic [GW-1:0] next_grp;
  assign next_grp = (32'(grp_q) + 1 >= 32'(eff_g)) ? '0 : grp_q + GW'(1);

  assign clr_busy_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxGroups; i++) begin
        fi_q[i] <= '0; fb_q[i] <= '0; ud_q[i] <= '0;
      end
      clr_q <= 1'b1; clr_cnt_q <= '0;
      idx_q <= '0; best_v_q <= 1'b0; best_q <= '0; grp_q <= '0; bit_q <= '0;
      tries_q <= '0; sfi_q <= '0; sud_q <= '0; avg_q <= '0; rem_q <= '0;
      dcnt_q <= '0; stat_q <= '0; ino_q <= '0; cg_q <= '0;
      req_q <= '0; alloc_done_q <= 1'b0;
    end else begin
      // post-reset bitmap clear sweep
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
        if (clr_cnt_q == (AW+1)'(Depth - 1)) clr_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        idx_q <= '0; sfi_q <= '0; sud_q <= '0; stat_q <= ST_NOSPC;
        ino_q <= '0; cg_q <= '0; alloc_done_q <= 1'b0;
        if (req_e'(req_i.req_type) == REQ_LOAD) begin
          stat_q <= ST_LOADED;
          if (lgrp_ok) begin
            fi_q[GW'(req_i.group_index)] <= req_i.free_inodes_value;
            fb_q[GW'(req_i.group_index)] <= req_i.free_blocks_value;
            ud_q[GW'(req_i.group_index)] <= req_i.used_dirs_value;
          end
        end else if (req_e'(req_i.req_type) == REQ_BIT) begin
          stat_q <= ST_LOADED;
        end
      end
      // totals: one group per cycle
      if (cmd_i.sum_step) begin
        sfi_q <= sfi_q + SW'(fi_q[gi]);
        sud_q <= sud_q + SW'(ud_q[gi]);
        idx_q <= sts_o.sum_last ? '0 : idx_q + GCW'(1);
        dcnt_q <= '0; avg_q <= '0; rem_q <= '0;
        best_v_q <= 1'b0;
      end
      // restoring divide of the free-inode sum by the group count
      if (cmd_i.div_step) begin
        logic [SW:0] r;
        r = {rem_q, sfi_q[SW-1 - dcnt_q]};
        if (r >= (SW+1)'(eff_g)) begin
          rem_q <= SW'(r - (SW+1)'(eff_g));
          avg_q <= {avg_q[SW-2:0], 1'b1};
        end else begin
          rem_q <= SW'(r);
          avg_q <= {avg_q[SW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 5'd1;
      end
      // pick: first group with the most free blocks among eligible
      if (cmd_i.pick_step) begin
        if (fi_q[gi] != '0 && SW'(fi_q[gi]) >= avg_q &&
            (!best_v_q || fb_q[best_q] < fb_q[gi])) begin
          best_v_q <= 1'b1; best_q <= gi;
          grp_q <= gi;
        end else if (!best_v_q) begin
          grp_q <= gi;
        end
        idx_q <= sts_o.pick_last ? '0 : idx_q + GCW'(1);
        bit_q <= '0; tries_q <= '0;
      end
      // bit scan, one bit per cycle apart from the bubble at the start of each group
      if (cmd_i.scan_step) begin
        if (!rd_ok) begin
          bit_q <= (BW+1)'(1);
        end else if (ram_rd) begin
          if (grp_end) begin
            grp_q <= next_grp; bit_q <= '0; tries_q <= tries_q + GCW'(1);
          end else begin
            bit_q <= bit_q + (BW+1)'(1);
          end
        end
      end
      if (cmd_i.commit) begin
        idx_q <= '0; sfi_q <= '0; sud_q <= '0; alloc_done_q <= 1'b1;
        if (insane) begin
          stat_q <= ST_INSANE;
        end else begin
          stat_q <= ST_OK; ino_q <= ino_w[11:0]; cg_q <= grp_q;
          if (fi_q[grp_q] != '0) fi_q[grp_q] <= fi_q[grp_q] - CntW'(1);
          ud_q[grp_q] <= ud_q[grp_q] + CntW'(1);
        end
      end
      if (cmd_i.capture) req_q <= req_i;
    end
  end

  // best_q keeps its last value when pick begins; best_v_q gates use
  assign rsp_o.status = stat_q;
  assign rsp_o.inode_number = ino_q;
  assign rsp_o.chosen_group = 3'(cg_q);
  assign rsp_o.free_inodes_total = TotW'(sfi_q);
  assign rsp_o.directories_total = TotW'(sud_q);
endmodule

// ----- rtl/core/directory_inode_allocator.sv -----
// Directory inode allocator: one request at a time, one response each.
// Loads, bit writes, file requests: totals summed over the G groups in use,
// then the response. Directory: sum, divide (20-step divide at default size),
// pick a group, scan the bitmap from it, commit, sum again; ST_NOSPC when none.
// Next request taken the cycle after the response.
// Reset: async active low; then a clear sweep of all MaxGroups*MaxInodesPerGroup bitmap bits.
module directory_inode_allocator #(
  parameter int unsigned MaxGroups         = 8,
  parameter int unsigned MaxInodesPerGroup = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [dia_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dia_pkg::CfgDataW-1:0] cfg_data_i,
  dia_if.sink   req_if,
  dia_if.source rsp_if
);
  import dia_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic clr_busy;
  rsp_t rsp;

  dia_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_if.valid), .in_ready_o(req_if.ready),
    .out_valid_o(rsp_if.valid), .out_ready_i(rsp_if.ready),
    .clr_busy_i(clr_busy), .cmd_o(cmd), .sts_i(sts)
  );

  dia_dp #(.MaxGroups(MaxGroups), .MaxIpg(MaxInodesPerGroup)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_if.data), .cmd_i(cmd), .sts_o(sts), .clr_busy_o(clr_busy),
    .rsp_o(rsp)
  );

  assign rsp_if.data = rsp;
endmodule
